// File: sv/mcp_pkg.sv
// Shared types, codes and constants for the motion command protocol block.
package mcp_pkg;

    // Event kinds on the input channel
    localparam logic [1:0] EVK_FRAME     = 2'd0;
    localparam logic [1:0] EVK_PROTO_ERR = 2'd1;
    localparam logic [1:0] EVK_DONE      = 2'd2;
    localparam logic [1:0] EVK_FAILED    = 2'd3;

    // Frame commands
    localparam logic [7:0] FC_QUERY  = 8'd0;
    localparam logic [7:0] FC_RESET  = 8'd1;
    localparam logic [7:0] FC_STOP   = 8'd2;
    localparam logic [7:0] FC_MOVE   = 8'd3;
    localparam logic [7:0] FC_ROTATE = 8'd4;

    // Reply kinds
    localparam logic [2:0] RK_NONE   = 3'd0;
    localparam logic [2:0] RK_ACK    = 3'd1;
    localparam logic [2:0] RK_ERROR  = 3'd2;
    localparam logic [2:0] RK_STATUS = 3'd3;
    localparam logic [2:0] RK_DONE   = 3'd4;

    // Motion events
    localparam logic [1:0] ME_NONE  = 2'd0;
    localparam logic [1:0] ME_START = 2'd1;
    localparam logic [1:0] ME_RESET = 2'd2;
    localparam logic [1:0] ME_STOP  = 2'd3;

    // Status codes as reported in replies
    localparam logic [7:0] SC_IDLE  = 8'd0;
    localparam logic [7:0] SC_BUSY  = 8'd1;
    localparam logic [7:0] SC_ERROR = 8'd2;

    // Active sequence reported when nothing has run
    localparam logic [7:0] NO_ACTIVE_SEQ = 8'hFF;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_DIR_MAX      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATE_DIR_MAX    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATE_SMALL_CODE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATE_LARGE_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAD_CMD_ERROR     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUSY_ERROR        = 3'd5;

    // Configuration reset values
    localparam logic [7:0] RST_MOVE_DIR_MAX      = 8'd3;
    localparam logic [7:0] RST_ROTATE_DIR_MAX    = 8'd1;
    localparam logic [7:0] RST_ROTATE_SMALL_CODE = 8'd1;
    localparam logic [7:0] RST_ROTATE_LARGE_CODE = 8'd2;
    localparam logic [7:0] RST_BAD_CMD_ERROR     = 8'd1;
    localparam logic [7:0] RST_BUSY_ERROR        = 8'd2;

    // Elapsed time scaling: divide by ten through a reciprocal, saturate at 255
    localparam int          MS_DIV_W     = 12;
    localparam logic [11:0] MS_SAT_LIMIT = 12'd2560;
    localparam logic [12:0] MS_RECIP     = 13'd6554;   // ceil(2^16 / 10)
    localparam int          MS_SHIFT     = 16;
    localparam logic [7:0]  MS_SAT_VAL   = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BUSY  = 3'b010,
        ST_ERROR = 3'b100
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  seq;
        logic [7:0]  frame_cmd;
        logic [7:0]  dir;
        logic [7:0]  val;
        logic [7:0]  error_code;
        logic [7:0]  err_context;
        logic [31:0] duration_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0] resp_kind;
        logic [7:0] resp_seq;
        logic [7:0] resp_dir;
        logic [7:0] resp_val;
        logic [1:0] drive_event;
        logic [7:0] action_seq;
        logic [7:0] action_cmd;
        logic [7:0] action_dir;
        logic [7:0] action_val;
    } out_item_t;

    typedef struct packed {
        logic [7:0] seq;
        logic [7:0] cmd;
        logic [7:0] dir;
        logic [7:0] val;
    } act_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] seq;
        logic [7:0] dir;
        logic [7:0] val;
    } reply_t;

    typedef struct packed {
        logic [7:0] move_dir_max;
        logic [7:0] rotate_dir_max;
        logic [7:0] rotate_small_code;
        logic [7:0] rotate_large_code;
        logic [7:0] bad_cmd_error_code;
        logic [7:0] busy_error_code;
    } cfg_t;

    function automatic logic [7:0] status_code(input status_t st);
        logic [7:0] code;
        case (st)
            ST_BUSY:  code = SC_BUSY;
            ST_ERROR: code = SC_ERROR;
            default:  code = SC_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: sv/mcp_cfg_regs.sv
// Configuration register file: six byte-wide limits and error codes.
module mcp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data,
    output mcp_pkg::cfg_t                      cfg
);

    mcp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_dir_max       <= mcp_pkg::RST_MOVE_DIR_MAX;
            cfg_reg.rotate_dir_max     <= mcp_pkg::RST_ROTATE_DIR_MAX;
            cfg_reg.rotate_small_code  <= mcp_pkg::RST_ROTATE_SMALL_CODE;
            cfg_reg.rotate_large_code  <= mcp_pkg::RST_ROTATE_LARGE_CODE;
            cfg_reg.bad_cmd_error_code <= mcp_pkg::RST_BAD_CMD_ERROR;
            cfg_reg.busy_error_code    <= mcp_pkg::RST_BUSY_ERROR;
        end else if (cfg_valid) begin
            // indexes past the list are dropped
            case (cfg_index)
                mcp_pkg::CFG_MOVE_DIR_MAX:      cfg_reg.move_dir_max       <= cfg_data;
                mcp_pkg::CFG_ROTATE_DIR_MAX:    cfg_reg.rotate_dir_max     <= cfg_data;
                mcp_pkg::CFG_ROTATE_SMALL_CODE: cfg_reg.rotate_small_code  <= cfg_data;
                mcp_pkg::CFG_ROTATE_LARGE_CODE: cfg_reg.rotate_large_code  <= cfg_data;
                mcp_pkg::CFG_BAD_CMD_ERROR:     cfg_reg.bad_cmd_error_code <= cfg_data;
                mcp_pkg::CFG_BUSY_ERROR:        cfg_reg.busy_error_code    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: sv/mcp_in_stage.sv
// Input register stage: captures one item and holds it until the core takes it.
module mcp_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mcp_pkg::in_item_t   s_item,
    output logic                item_valid,
    output mcp_pkg::in_item_t   item,
    input  logic                item_take
);

    logic              valid_reg;
    mcp_pkg::in_item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: sv/mcp_core.sv
// Protocol core: unit state, reply logic and the result register.
module mcp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  mcp_pkg::cfg_t       cfg,
    input  logic                item_valid,
    input  mcp_pkg::in_item_t   item,
    output logic                item_take,
    output logic                m_valid,
    input  logic                m_ready,
    output mcp_pkg::out_item_t  m_item
);

    mcp_pkg::status_t   status_reg, status_next;
    logic               has_prior_reg, has_prior_next;
    mcp_pkg::act_t      prior_reg, prior_next;
    logic               reply_valid_reg, reply_valid_next;
    mcp_pkg::reply_t    stored_reg, stored_next;
    mcp_pkg::act_t      running_reg, running_next;
    logic               out_valid_reg;
    mcp_pkg::out_item_t out_reg, res;

    mcp_pkg::act_t      frame;
    logic               is_dup, dup_match, simple, frame_bad;
    logic               ms_sat;
    logic [24:0]        ms_prod;
    logic [7:0]         ms_tens;

    assign item_take = item_valid && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    assign frame.seq = item.seq;
    assign frame.cmd = item.frame_cmd;
    assign frame.dir = item.dir;
    assign frame.val = item.val;

    assign is_dup    = has_prior_reg && (frame.seq == prior_reg.seq);
    assign dup_match = (frame.cmd == prior_reg.cmd) && (frame.dir == prior_reg.dir)
                       && (frame.val == prior_reg.val);
    assign simple    = (frame.dir == 8'd0) && (frame.val == 8'd0);

    always_comb begin
        case (frame.cmd)
            mcp_pkg::FC_MOVE:
                frame_bad = (frame.val == 8'd0) || (frame.dir > cfg.move_dir_max);
            mcp_pkg::FC_ROTATE:
                frame_bad = (frame.dir > cfg.rotate_dir_max)
                            || ((frame.val != cfg.rotate_small_code)
                                && (frame.val != cfg.rotate_large_code));
            default:
                frame_bad = 1'b1;
        endcase
    end

    // tens of milliseconds: reciprocal multiply below the saturation point
    assign ms_sat  = (|item.duration_ms[31:mcp_pkg::MS_DIV_W])
                     || (item.duration_ms[mcp_pkg::MS_DIV_W-1:0] >= mcp_pkg::MS_SAT_LIMIT);
    assign ms_prod = {13'd0, item.duration_ms[mcp_pkg::MS_DIV_W-1:0]}
                     * {12'd0, mcp_pkg::MS_RECIP};
    assign ms_tens = ms_sat ? mcp_pkg::MS_SAT_VAL
                            : ms_prod[mcp_pkg::MS_SHIFT+7:mcp_pkg::MS_SHIFT];

    always_comb begin
        status_next      = status_reg;
        has_prior_next   = has_prior_reg;
        prior_next       = prior_reg;
        reply_valid_next = reply_valid_reg;
        stored_next      = stored_reg;
        running_next     = running_reg;
        res              = '0;

        case (item.cmd)
            mcp_pkg::EVK_FRAME: begin
                if (is_dup) begin
                    if (dup_match) begin
                        if (reply_valid_reg) begin
                            res.resp_kind = stored_reg.kind;
                            res.resp_seq  = stored_reg.seq;
                            res.resp_dir  = stored_reg.dir;
                            res.resp_val  = stored_reg.val;
                        end else begin
                            res.resp_kind = mcp_pkg::RK_ACK;
                            res.resp_seq  = frame.seq;
                            res.resp_dir  = frame.dir;
                            res.resp_val  = frame.val;
                        end
                    end else begin
                        res.resp_kind = mcp_pkg::RK_ERROR;
                        res.resp_seq  = frame.seq;
                        res.resp_dir  = cfg.bad_cmd_error_code;
                        res.resp_val  = frame.cmd;
                        status_next   = mcp_pkg::ST_ERROR;
                    end
                end else if (frame.cmd <= mcp_pkg::FC_STOP) begin
                    res.resp_seq = frame.seq;
                    if (!simple) begin
                        res.resp_kind = mcp_pkg::RK_ERROR;
                        res.resp_dir  = cfg.bad_cmd_error_code;
                        res.resp_val  = frame.cmd;
                        status_next   = mcp_pkg::ST_ERROR;
                    end else begin
                        case (frame.cmd)
                            mcp_pkg::FC_QUERY: begin
                                res.resp_kind = mcp_pkg::RK_STATUS;
                                res.resp_dir  = mcp_pkg::status_code(status_reg);
                                if (status_reg == mcp_pkg::ST_BUSY) begin
                                    res.resp_val = running_reg.seq;
                                end else if (has_prior_reg) begin
                                    res.resp_val = prior_reg.seq;
                                end else begin
                                    res.resp_val = mcp_pkg::NO_ACTIVE_SEQ;
                                end
                            end
                            mcp_pkg::FC_RESET: begin
                                // clear all unit state, keep configuration
                                status_next      = mcp_pkg::ST_IDLE;
                                has_prior_next   = 1'b0;
                                prior_next       = '0;
                                reply_valid_next = 1'b0;
                                stored_next      = '0;
                                running_next     = '0;
                                res.resp_kind    = mcp_pkg::RK_ACK;
                                res.drive_event  = mcp_pkg::ME_RESET;
                            end
                            default: begin
                                status_next      = mcp_pkg::ST_ERROR;
                                running_next     = '0;
                                res.resp_kind    = mcp_pkg::RK_ACK;
                                res.drive_event  = mcp_pkg::ME_STOP;
                            end
                        endcase
                    end
                end else if (status_reg == mcp_pkg::ST_ERROR) begin
                    res.resp_kind = mcp_pkg::RK_ERROR;
                    res.resp_seq  = frame.seq;
                    res.resp_dir  = cfg.busy_error_code;
                    res.resp_val  = mcp_pkg::SC_ERROR;
                end else if (frame_bad) begin
                    res.resp_kind = mcp_pkg::RK_ERROR;
                    res.resp_seq  = frame.seq;
                    res.resp_dir  = cfg.bad_cmd_error_code;
                    res.resp_val  = frame.cmd;
                    status_next   = mcp_pkg::ST_ERROR;
                end else if (status_reg == mcp_pkg::ST_BUSY) begin
                    res.resp_kind = mcp_pkg::RK_ERROR;
                    res.resp_seq  = frame.seq;
                    res.resp_dir  = cfg.busy_error_code;
                    res.resp_val  = running_reg.seq;
                end else begin
                    // acknowledge and start the action
                    res.resp_kind    = mcp_pkg::RK_ACK;
                    res.resp_seq     = frame.seq;
                    res.resp_dir     = frame.dir;
                    res.resp_val     = frame.val;
                    res.drive_event  = mcp_pkg::ME_START;
                    res.action_seq   = frame.seq;
                    res.action_cmd   = frame.cmd;
                    res.action_dir   = frame.dir;
                    res.action_val   = frame.val;
                    status_next      = mcp_pkg::ST_BUSY;
                    has_prior_next   = 1'b1;
                    prior_next       = frame;
                    running_next     = frame;
                    stored_next.kind = mcp_pkg::RK_ACK;
                    stored_next.seq  = frame.seq;
                    stored_next.dir  = frame.dir;
                    stored_next.val  = frame.val;
                    reply_valid_next = 1'b1;
                end
            end
            mcp_pkg::EVK_PROTO_ERR: begin
                res.resp_kind = mcp_pkg::RK_ERROR;
                res.resp_seq  = item.seq;
                res.resp_dir  = item.error_code;
                res.resp_val  = item.err_context;
                status_next   = mcp_pkg::ST_ERROR;
            end
            default: begin
                // done or failed reports count only while busy
                if (status_reg == mcp_pkg::ST_BUSY) begin
                    stored_next.seq = running_reg.seq;
                    if (item.cmd == mcp_pkg::EVK_DONE) begin
                        stored_next.kind = mcp_pkg::RK_DONE;
                        stored_next.dir  = running_reg.dir;
                        stored_next.val  = ms_tens;
                        status_next      = mcp_pkg::ST_IDLE;
                    end else begin
                        stored_next.kind = mcp_pkg::RK_ERROR;
                        stored_next.dir  = item.error_code;
                        stored_next.val  = item.err_context;
                        status_next      = mcp_pkg::ST_ERROR;
                    end
                    reply_valid_next = 1'b1;
                    res.resp_kind    = stored_next.kind;
                    res.resp_seq     = stored_next.seq;
                    res.resp_dir     = stored_next.dir;
                    res.resp_val     = stored_next.val;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= mcp_pkg::ST_IDLE;
            has_prior_reg   <= 1'b0;
            prior_reg       <= '0;
            reply_valid_reg <= 1'b0;
            stored_reg      <= '0;
            running_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (item_take) begin
                status_reg      <= status_next;
                has_prior_reg   <= has_prior_next;
                prior_reg       <= prior_next;
                reply_valid_reg <= reply_valid_next;
                stored_reg      <= stored_next;
                running_reg     <= running_next;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            out_reg <= res;
        end
    end

    // a started action leaves the unit busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && (res.drive_event == mcp_pkg::ME_START))
        |=> (status_reg == mcp_pkg::ST_BUSY))
        else $error("unit not busy after an action start");

    // action fields are zero unless an action starts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.drive_event != mcp_pkg::ME_START))
        |-> ({out_reg.action_seq, out_reg.action_cmd, out_reg.action_dir,
              out_reg.action_val} == 32'd0))
        else $error("action fields set without an action start");

    // a start is always acknowledged with its own sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.drive_event == mcp_pkg::ME_START))
        |-> ((out_reg.resp_kind == mcp_pkg::RK_ACK)
             && (out_reg.resp_seq == out_reg.action_seq)))
        else $error("action start without a matching ack");

    // busy state and stored replies only exist after an accepted action
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((status_reg == mcp_pkg::ST_BUSY) || reply_valid_reg) |-> has_prior_reg)
        else $error("busy or stored reply without a prior action");

    // a result held for a stalled receiver does not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("held result changed under stall");

endmodule

// File: sv/motion_command_protocol.sv
// Motion command protocol front end: top level.
//
// Usage:
//   s_valid/s_ready/s_item carry one event per item: a received frame, a link
//   protocol error, a motion-done report or a motion-failure report.
//   m_valid/m_ready/m_item return exactly one result item per event: the
//   reply (kind, seq, dir, val) and any motion event with its action fields.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the six limit and error-code
//   registers; cfg_ready is always high. Write them only while no item is in
//   flight.
// Path: an accepted item goes through the input register, then the state
//   update into the result register that drives m_valid and m_item.
// Throughput: one item per cycle while m_ready is high; the core's state
//   update is registered per item, so each item sees the state left by the
//   one before it.
// Reset: aresetn low clears both stages, sets the unit idle with no prior
//   action or stored reply and loads the register defaults.
// Stall: with m_ready low the result holds, the input register still fills
//   once, and s_ready then drops until the result is taken.
module motion_command_protocol (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mcp_pkg::in_item_t                s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mcp_pkg::out_item_t               m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);

    mcp_pkg::cfg_t     cfg;
    logic              item_valid;
    logic              item_take;
    mcp_pkg::in_item_t item;

    mcp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mcp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// File: tb/mcp_reply_checker.sv
// Reply checker for the motion command protocol block: predicts each reply and compares it.
`timescale 1ns / 1ps

module mcp_reply_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  mcp_pkg::in_item_t               s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  mcp_pkg::out_item_t              m_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mcp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    output int                              replies_due,
    output int                              mismatch_count
);
    import mcp_pkg::*;

    cfg_t       limits;
    logic [7:0] unit_state;
    logic       started_any;
    act_t       prior_act;
    logic       reply_held;
    reply_t     held_reply;
    act_t       running_act;
    out_item_t  expected_replies[$];
    int         mismatches = 0;

    assign mismatch_count = mismatches;

    function automatic void clear_unit();
        unit_state  = SC_IDLE;
        started_any = 1'b0;
        prior_act   = '0;
        reply_held  = 1'b0;
        held_reply  = '0;
        running_act = '0;
    endfunction

    function automatic out_item_t reply_of(input logic [2:0] kind,
                                           input logic [7:0] seq, dir, val);
        out_item_t r;
        r           = '0;
        r.resp_kind = kind;
        r.resp_seq  = seq;
        r.resp_dir  = dir;
        r.resp_val  = val;
        return r;
    endfunction

    function automatic out_item_t reject_frame(input act_t f);
        unit_state = SC_ERROR;
        return reply_of(RK_ERROR, f.seq, limits.bad_cmd_error_code, f.cmd);
    endfunction

    function automatic out_item_t predict_frame(input act_t f);
        out_item_t  r;
        logic       plain;
        logic       fits;
        logic [7:0] tag;
        plain = (f.dir == 8'd0) && (f.val == 8'd0);
        // a repeated sequence number either replays or is rejected outright
        if (started_any && f.seq == prior_act.seq) begin
            if (f != prior_act)
                return reject_frame(f);
            if (reply_held)
                return reply_of(held_reply.kind, held_reply.seq, held_reply.dir, held_reply.val);
            return reply_of(RK_ACK, f.seq, f.dir, f.val);
        end
        if (f.cmd == FC_QUERY || f.cmd == FC_RESET || f.cmd == FC_STOP) begin
            if (!plain)
                return reject_frame(f);
            if (f.cmd == FC_QUERY) begin
                if (unit_state == SC_BUSY)
                    tag = running_act.seq;
                else if (started_any)
                    tag = prior_act.seq;
                else
                    tag = NO_ACTIVE_SEQ;
                return reply_of(RK_STATUS, f.seq, unit_state, tag);
            end
            r = reply_of(RK_ACK, f.seq, f.dir, f.val);
            if (f.cmd == FC_RESET) begin
                clear_unit();
                r.drive_event = ME_RESET;
            end else begin
                unit_state    = SC_ERROR;
                running_act   = '0;
                r.drive_event = ME_STOP;
            end
            return r;
        end
        if (unit_state == SC_ERROR)
            return reply_of(RK_ERROR, f.seq, limits.busy_error_code, SC_ERROR);
        if (f.cmd == FC_MOVE)
            fits = (f.val != 8'd0) && (f.dir <= limits.move_dir_max);
        else if (f.cmd == FC_ROTATE)
            fits = (f.dir <= limits.rotate_dir_max) &&
                   (f.val == limits.rotate_small_code || f.val == limits.rotate_large_code);
        else
            fits = 1'b0;
        if (!fits)
            return reject_frame(f);
        if (unit_state == SC_BUSY)
            return reply_of(RK_ERROR, f.seq, limits.busy_error_code, running_act.seq);
        unit_state  = SC_BUSY;
        started_any = 1'b1;
        prior_act   = f;
        running_act = f;
        held_reply  = '{kind: RK_ACK, seq: f.seq, dir: f.dir, val: f.val};
        reply_held  = 1'b1;
        r = reply_of(RK_ACK, f.seq, f.dir, f.val);
        r.drive_event = ME_START;
        r.action_seq  = f.seq;
        r.action_cmd  = f.cmd;
        r.action_dir  = f.dir;
        r.action_val  = f.val;
        return r;
    endfunction

    function automatic out_item_t predict_reply(input in_item_t it);
        out_item_t   r;
        logic [31:0] tens;
        r = '0;
        case (it.cmd)
            EVK_FRAME: r = predict_frame({it.seq, it.frame_cmd, it.dir, it.val});
            EVK_PROTO_ERR: begin
                r = reply_of(RK_ERROR, it.seq, it.error_code, it.err_context);
                unit_state = SC_ERROR;
            end
            default: begin
                // reports while not busy leave everything alone and answer with zeros
                if (unit_state == SC_BUSY) begin
                    held_reply.seq = running_act.seq;
                    if (it.cmd == EVK_DONE) begin
                        tens            = it.duration_ms / 32'd10;
                        held_reply.kind = RK_DONE;
                        held_reply.dir  = running_act.dir;
                        held_reply.val  = (tens > 32'd255) ? 8'hFF : tens[7:0];
                        unit_state      = SC_IDLE;
                    end else begin
                        held_reply.kind = RK_ERROR;
                        held_reply.dir  = it.error_code;
                        held_reply.val  = it.err_context;
                        unit_state      = SC_ERROR;
                    end
                    reply_held = 1'b1;
                    r = reply_of(held_reply.kind, held_reply.seq, held_reply.dir, held_reply.val);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            clear_unit();
            limits = '{RST_MOVE_DIR_MAX, RST_ROTATE_DIR_MAX, RST_ROTATE_SMALL_CODE,
                       RST_ROTATE_LARGE_CODE, RST_BAD_CMD_ERROR, RST_BUSY_ERROR};
            expected_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MOVE_DIR_MAX:      limits.move_dir_max       = cfg_data;
                    CFG_ROTATE_DIR_MAX:    limits.rotate_dir_max     = cfg_data;
                    CFG_ROTATE_SMALL_CODE: limits.rotate_small_code  = cfg_data;
                    CFG_ROTATE_LARGE_CODE: limits.rotate_large_code  = cfg_data;
                    CFG_BAD_CMD_ERROR:     limits.bad_cmd_error_code = cfg_data;
                    CFG_BUSY_ERROR:        limits.busy_error_code    = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, m_item);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_item !== want) begin
                        $display("%0t: result expected %h actual %h", $time, want, m_item);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_replies.push_back(predict_reply(s_item));
        end
        replies_due <= expected_replies.size();
    end

endmodule

// File: tb/tb_motion_command_protocol.sv
// Testbench top for the motion command protocol block: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_motion_command_protocol;
    import mcp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 285;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    int       replies_due;
    int       mismatch_count;
    int       quiet_cycles = 0;
    int       burst_left   = 0;
    rx_mode_t rx_mode      = RX_ALWAYS;
    logic [7:0] fresh_seq  = 8'd40;
    act_t     last_frame   = '0;
    cfg_t     cfg_now      = '{RST_MOVE_DIR_MAX, RST_ROTATE_DIR_MAX, RST_ROTATE_SMALL_CODE,
                               RST_ROTATE_LARGE_CODE, RST_BAD_CMD_ERROR, RST_BUSY_ERROR};

    motion_command_protocol DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mcp_reply_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .replies_due    (replies_due),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: stall pattern chosen by the current mode
    initial begin
        int on_len;
        int off_len;
        @(posedge aclk);
        forever begin
            case (rx_mode)
                RX_ALWAYS: begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end
                RX_RANDOM: begin
                    m_ready <= ($urandom_range(0, 2) != 0);
                    @(posedge aclk);
                end
                RX_PATTERN: begin
                    on_len  = $urandom_range(1, 8);
                    off_len = $urandom_range(1, 5);
                    m_ready <= 1'b1;
                    repeat (on_len) @(posedge aclk);
                    m_ready <= 1'b0;
                    repeat (off_len) @(posedge aclk);
                end
                RX_HOLD: begin
                    // hold off long enough for the block to fill and stall its input
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    repeat (60) begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                        @(posedge aclk);
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_motion_command_protocol: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_item_t make_item(input logic [1:0] kind,
                                           input logic [7:0] seq, fc, dir, val, ec, ctx,
                                           input logic [31:0] ms);
        return '{cmd: kind, seq: seq, frame_cmd: fc, dir: dir, val: val,
                 error_code: ec, err_context: ctx, duration_ms: ms};
    endfunction

    function automatic in_item_t next_random_item();
        logic [95:0] raw;
        in_item_t    it;
        int          pick;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return it;
        it.cmd    = EVK_FRAME;
        fresh_seq = fresh_seq + 8'd1;
        it.seq    = fresh_seq;
        if (pick < 32) begin
            it.frame_cmd = FC_MOVE;
            it.dir       = 8'($urandom_range(0, cfg_now.move_dir_max));
            it.val       = 8'($urandom_range(1, 255));
            last_frame   = {it.seq, it.frame_cmd, it.dir, it.val};
        end else if (pick < 42) begin
            it.frame_cmd = FC_ROTATE;
            it.dir       = 8'($urandom_range(0, cfg_now.rotate_dir_max));
            it.val       = $urandom_range(0, 1) ? cfg_now.rotate_small_code
                                                : cfg_now.rotate_large_code;
            last_frame   = {it.seq, it.frame_cmd, it.dir, it.val};
        end else if (pick < 57) begin
            it.cmd = EVK_DONE;
            case ($urandom_range(0, 4))
                0: it.duration_ms = $urandom_range(0, 2600);
                1: it.duration_ms = $urandom_range(2540, 2570);
                2: it.duration_ms = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
                3: it.duration_ms = $urandom_range(0, 99);
                default: ;
            endcase
        end else if (pick < 61) begin
            it.cmd = EVK_FAILED;
        end else if (pick < 64) begin
            it.cmd = EVK_PROTO_ERR;
        end else if (pick < 85) begin
            if (pick < 72)
                it.frame_cmd = FC_QUERY;
            else if (pick < 82)
                it.frame_cmd = FC_RESET;
            else
                it.frame_cmd = FC_STOP;
            it.dir = 8'd0;
            it.val = 8'd0;
        end else if (pick < 92) begin
            {it.seq, it.frame_cmd, it.dir, it.val} = last_frame;
        end else if (pick < 95) begin
            {it.seq, it.frame_cmd, it.dir, it.val} = last_frame;
            it.val = it.val ^ 8'($urandom_range(1, 255));
        end else begin
            // frames meant to break the configured limits; a random rotate can still fit
            it.frame_cmd = FC_MOVE;
            case ($urandom_range(0, 3))
                0: begin
                    if (cfg_now.move_dir_max != 8'hFF)
                        it.dir = 8'($urandom_range(cfg_now.move_dir_max + 1, 255));
                    else
                        it.val = 8'd0;
                end
                1: it.val = 8'd0;
                2: it.frame_cmd = FC_ROTATE;
                default: it.frame_cmd = 8'($urandom_range(5, 255));
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (replies_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_config(input cfg_t c);
        logic [CFG_INDEX_W-1:0] idx[6];
        logic [7:0]             vals[6];
        idx  = '{CFG_MOVE_DIR_MAX, CFG_ROTATE_DIR_MAX, CFG_ROTATE_SMALL_CODE,
                 CFG_ROTATE_LARGE_CODE, CFG_BAD_CMD_ERROR, CFG_BUSY_ERROR};
        vals = '{c.move_dir_max, c.rotate_dir_max, c.rotate_small_code,
                 c.rotate_large_code, c.bad_cmd_error_code, c.busy_error_code};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_now = c;
    endtask

    task automatic run_phase(input rx_mode_t mode);
        rx_mode <= mode;
        repeat (PHASE_ITEMS) send_item(next_random_item());
        drain();
    endtask

    initial begin
        logic [63:0] raw;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        rx_mode <= RX_RANDOM;
        @(posedge aclk);

        // directed items on the reset limits
        send_item(make_item(EVK_FRAME, 8'd0, FC_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_DONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF));
        send_item(make_item(EVK_FAILED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd1, FC_MOVE, 8'd3, 8'hFF, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd2, FC_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd3, FC_MOVE, 8'd0, 8'd1, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_DONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF));
        send_item(make_item(EVK_FRAME, 8'd1, FC_MOVE, 8'd3, 8'hFF, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd4, FC_ROTATE, 8'd1, 8'd2, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_DONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd2549));
        send_item(make_item(EVK_FRAME, 8'd5, FC_ROTATE, 8'd0, 8'd1, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FAILED, 8'd0, 8'd0, 8'd0, 8'd0, 8'hAA, 8'h55, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd6, FC_MOVE, 8'd0, 8'd1, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd7, FC_STOP, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd8, FC_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd9, FC_RESET, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd5, FC_MOVE, 8'd1, 8'd7, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd5, FC_MOVE, 8'd1, 8'd8, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd10, FC_RESET, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd11, FC_QUERY, 8'd1, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd12, FC_RESET, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd13, FC_MOVE, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd14, FC_RESET, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_FRAME, 8'd17, FC_ROTATE, 8'd0, 8'd3, 8'd0, 8'd0, 32'd0));
        send_item(make_item(EVK_PROTO_ERR, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 32'd0));
        drain();

        run_phase(RX_ALWAYS);
        load_config('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        run_phase(RX_RANDOM);
        load_config('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        run_phase(RX_PATTERN);
        raw = {$urandom, $urandom};
        load_config(raw[47:0]);
        run_phase(RX_HOLD);
        load_config('{8'd7, 8'd3, 8'd5, 8'd9, 8'h80, 8'h7F});
        run_phase(RX_RANDOM);
        raw = {$urandom, $urandom};
        load_config(raw[47:0]);
        run_phase(RX_PATTERN);

        if (mismatch_count == 0)
            $display("tb_motion_command_protocol: clean");
        else
            $display("tb_motion_command_protocol: errors");
        $finish;
    end

endmodule

// File: sim.f
sv/mcp_pkg.sv
sv/mcp_cfg_regs.sv
sv/mcp_in_stage.sv
sv/mcp_core.sv
sv/motion_command_protocol.sv
tb/mcp_reply_checker.sv
tb/tb_motion_command_protocol.sv
